### rtl/core/mfq_pkg.sv
// Shared types and constants of the multilevel feedback scheduler.
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

    // Fixed field widths of the stream words.
    localparam int ID_W        = 4;
    localparam int SVC_W       = 10;
    localparam int RLVL_W      = 3;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes carried in the input tuser bit.
    typedef enum logic [0:0] {
        OP_ARRIVE = 1'b0,
        OP_TICK   = 1'b1
    } op_kind_t;

    // Classified command passed from front to back.
    typedef struct packed {
        op_kind_t          kind;
        logic [ID_W-1:0]   proc_id;
        logic [SVC_W-1:0]  service_time;
    } mfq_cmd_t;

    // One tick report.
    typedef struct packed {
        logic              busy;
        logic [ID_W-1:0]   run_id;
        logic [RLVL_W-1:0] run_level;
        logic              done;
    } mfq_result_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD_ID,
        BK_LOAD,
        BK_EXEC
    } bk_state_t;

endpackage

`default_nettype wire

### rtl/core/mfq_front.sv
// Front end: accepts input words, decodes them and drops arrivals that can never enter.
`timescale 1ns / 1ps
`default_nettype none

module mfq_front #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [mfq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tuser,
    input  wire logic                            queue_full,
    output logic                                 push_en,
    output mfq_pkg::mfq_cmd_t                    push_cmd
);
    import mfq_pkg::*;

    logic [ID_W-1:0]  word_id;
    logic [SVC_W-1:0] word_svc;
    op_kind_t         word_kind;
    logic             id_ok;
    logic             keep;

    // Unpack the word.
    assign word_id   = s_axis_tdata[ID_W-1:0];
    assign word_svc  = s_axis_tdata[ID_W+SVC_W-1:ID_W];
    assign word_kind = op_kind_t'(s_axis_tuser);

    // Arrivals with no service or an ID beyond the table are consumed and dropped.
    assign id_ok = ({{(32-ID_W){1'b0}}, word_id} < 32'(MAX_PROCS));
    assign keep  = (word_kind == OP_TICK) || ((word_svc != '0) && id_ok);

    assign s_axis_tready = !queue_full;
    assign push_en       = s_axis_tvalid && !queue_full && keep;

    always_comb
    begin
        push_cmd.kind         = word_kind;
        push_cmd.proc_id      = word_id;
        push_cmd.service_time = word_svc;
    end

endmodule

`default_nettype wire

### rtl/core/mfq_queue.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module mfq_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire mfq_pkg::mfq_cmd_t  wr_cmd,
    output logic                    full,
    output logic                    rd_valid,
    output mfq_pkg::mfq_cmd_t       rd_cmd,
    input  wire logic               rd_en
);
    import mfq_pkg::*;

    mfq_cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && rd_valid;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mfq_back.sv
// Back end: level queues, dispatch, service accounting and the result register.
`timescale 1ns / 1ps
`default_nettype none

module mfq_back #(
    parameter int MAX_PROCS  = 16,
    parameter int NUM_LEVELS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_wr_data,
    input  wire logic                   cmd_valid,
    input  wire mfq_pkg::mfq_cmd_t      cmd,
    output logic                        cmd_pop,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output mfq_pkg::mfq_result_t        res
);
    import mfq_pkg::*;

    localparam int PID_W      = $clog2(MAX_PROCS);
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int CNT_W      = $clog2(MAX_PROCS + 1);
    localparam int QW         = NUM_LEVELS;
    localparam int FIFO_DEPTH = NUM_LEVELS << PID_W;
    localparam int FA_W       = LVL_W + PID_W;

    // Sequencer and process state.
    bk_state_t           state_reg, state_next;
    logic                quantum_mode_reg;
    logic [MAX_PROCS-1:0] live_reg;
    logic [PID_W-1:0]    head_reg [NUM_LEVELS];
    logic [PID_W-1:0]    tail_reg [NUM_LEVELS];
    logic [CNT_W-1:0]    count_reg [NUM_LEVELS];
    logic                running_reg;
    logic [ID_W-1:0]     cur_id_reg;
    logic [LVL_W-1:0]    cur_level_reg;
    logic [QW-1:0]       quantum_reg;
    logic [SVC_W-1:0]    rem_reg;

    // Memories.
    logic [ID_W-1:0]     fifo_mem [FIFO_DEPTH];
    logic [ID_W-1:0]     fifo_rdata_reg;
    logic [SVC_W-1:0]    svc_mem [MAX_PROCS];
    logic [SVC_W-1:0]    svc_rdata_reg;

    // Output register.
    logic                out_valid_reg;
    mfq_result_t         out_res_reg;

    // Control strobes.
    logic                slot_free;
    logic                do_arrive;
    logic                do_dispatch;
    logic                do_idle_res;
    logic                do_exec;
    logic                do_fetch_id;
    logic                do_load;

    // Derived values.
    logic [NUM_LEVELS-1:0] nonempty;
    logic                any_queued;
    logic [LVL_W-1:0]    sel_lvl;
    logic [PID_W-1:0]    arr_idx;
    logic [SVC_W-1:0]    rem_new;
    logic [QW-1:0]       quantum_new;
    logic                finish;
    logic                requeue;
    logic [LVL_W-1:0]    requeue_lvl;
    logic                push_en;
    logic [LVL_W-1:0]    push_lvl;
    logic [ID_W-1:0]     push_id;
    logic                pop_en;
    mfq_result_t         res_word;

    assign slot_free = !out_valid_reg || res_ready;
    assign arr_idx   = PID_W'(cmd.proc_id);

    // Find the lowest non-empty level.
    always_comb
    begin
        sel_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            nonempty[l] = (count_reg[l] != '0);
            if (count_reg[l] != '0)
            begin
                sel_lvl = LVL_W'(l);
            end
        end
    end
    assign any_queued = |nonempty;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == OP_TICK)
                begin
                    if (running_reg)
                    begin
                        state_next = BK_EXEC;
                    end
                    else if (any_queued)
                    begin
                        state_next = BK_RD_ID;
                    end
                end
            end
            BK_RD_ID:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                state_next = BK_EXEC;
            end
            BK_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_pop     = 1'b0;
        do_arrive   = 1'b0;
        do_dispatch = 1'b0;
        do_idle_res = 1'b0;
        do_exec     = 1'b0;
        do_fetch_id = 1'b0;
        do_load     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == OP_ARRIVE)
                    begin
                        cmd_pop   = 1'b1;
                        do_arrive = !live_reg[arr_idx];
                    end
                    else if (running_reg)
                    begin
                        cmd_pop = 1'b1;
                    end
                    else if (any_queued)
                    begin
                        cmd_pop     = 1'b1;
                        do_dispatch = 1'b1;
                    end
                    else if (slot_free)
                    begin
                        cmd_pop     = 1'b1;
                        do_idle_res = 1'b1;
                    end
                end
            end
            BK_RD_ID:
            begin
                do_fetch_id = 1'b1;
            end
            BK_LOAD:
            begin
                do_load = 1'b1;
            end
            BK_EXEC:
            begin
                do_exec = slot_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Tick arithmetic for the running process.
    assign rem_new     = rem_reg - 1'b1;
    assign quantum_new = quantum_reg - 1'b1;
    assign finish      = (rem_new == '0);
    assign requeue     = do_exec && !finish && (quantum_new == '0);

    // A lone process stays at its level; others sink one level, the last level holds.
    always_comb
    begin
        requeue_lvl = cur_level_reg;
        if (any_queued && cur_level_reg != LVL_W'(NUM_LEVELS - 1))
        begin
            requeue_lvl = cur_level_reg + 1'b1;
        end
    end

    // Level queue push and pop.
    assign push_lvl = do_arrive ? '0 : requeue_lvl;
    assign push_id  = do_arrive ? cmd.proc_id : cur_id_reg;
    assign push_en  = (do_arrive || requeue) && (count_reg[push_lvl] != CNT_W'(MAX_PROCS));
    assign pop_en   = do_dispatch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            if (push_en)
            begin
                tail_reg[push_lvl]  <= (tail_reg[push_lvl] == PID_W'(MAX_PROCS - 1)) ?
                                       '0 : tail_reg[push_lvl] + 1'b1;
                count_reg[push_lvl] <= count_reg[push_lvl] + 1'b1;
            end
            if (pop_en)
            begin
                head_reg[sel_lvl]  <= (head_reg[sel_lvl] == PID_W'(MAX_PROCS - 1)) ?
                                      '0 : head_reg[sel_lvl] + 1'b1;
                count_reg[sel_lvl] <= count_reg[sel_lvl] - 1'b1;
            end
        end
    end

    // Level queue memory, all levels side by side.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            fifo_mem[FA_W'({push_lvl, tail_reg[push_lvl]})] <= push_id;
        end
        if (pop_en)
        begin
            fifo_rdata_reg <= fifo_mem[FA_W'({sel_lvl, head_reg[sel_lvl]})];
        end
    end

    // Remaining service memory, written on arrival and when a process is requeued.
    always_ff @(posedge clk)
    begin
        if (do_arrive)
        begin
            svc_mem[arr_idx] <= cmd.service_time;
        end
        else if (requeue)
        begin
            svc_mem[PID_W'(cur_id_reg)] <= rem_new;
        end
        if (do_fetch_id)
        begin
            svc_rdata_reg <= svc_mem[PID_W'(fifo_rdata_reg)];
        end
    end

    // Sequencer, configuration and running-process registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            quantum_mode_reg <= 1'b1;
            live_reg         <= '0;
            running_reg      <= 1'b0;
            cur_id_reg       <= '0;
            cur_level_reg    <= '0;
            quantum_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                quantum_mode_reg <= cfg_wr_data;
            end
            if (do_arrive)
            begin
                live_reg[arr_idx] <= 1'b1;
            end
            if (do_dispatch)
            begin
                running_reg   <= 1'b1;
                cur_level_reg <= sel_lvl;
                quantum_reg   <= quantum_mode_reg ?
                                 ({{(QW-1){1'b0}}, 1'b1} << sel_lvl) : {{(QW-1){1'b0}}, 1'b1};
            end
            if (do_fetch_id)
            begin
                cur_id_reg <= fifo_rdata_reg;
            end
            if (do_exec)
            begin
                quantum_reg <= quantum_new;
                if (finish)
                begin
                    live_reg[PID_W'(cur_id_reg)] <= 1'b0;
                    running_reg                  <= 1'b0;
                end
                else if (quantum_new == '0)
                begin
                    running_reg <= 1'b0;
                end
            end
        end
    end

    // Remaining service of the running process.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            rem_reg <= svc_rdata_reg;
        end
        else if (do_exec)
        begin
            rem_reg <= rem_new;
        end
    end

    // Result word for the current tick.
    always_comb
    begin
        res_word = '0;
        if (do_exec)
        begin
            res_word.busy      = 1'b1;
            res_word.run_id    = cur_id_reg;
            res_word.run_level = RLVL_W'(cur_level_reg);
            res_word.done      = finish;
        end
    end

    // Output register; it is refilled in the cycle the receiver takes its word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= do_exec || do_idle_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_res_reg <= res_word;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule

`default_nettype wire

### rtl/core/multilevel_feedback_scheduler_core.sv
// Top level of the multilevel feedback queue scheduler.
//
// Input stream (s_axis): tuser is the operation (0 arrive, 1 tick); tdata carries
// proc_id in bits 3:0 and service_time in bits 13:4. Arrivals produce no word;
// each tick produces exactly one word on the output stream (m_axis): tuser is
// busy_res, tlast is done_res, tdata carries run_id in bits 3:0 and run_level
// in bits 6:4. An idle tick gives an all-zero word.
// A two-entry command queue sits behind the input port, so words are taken
// while the back end works. The back end handles an arrival or an idle tick in
// its idle state, a tick of the running process in its execute state, and a
// tick that must first dispatch from the level queues through its read-ID and
// load states before executing: a read of the level queue memory and then a
// read of the service memory.
// When the receiver stalls, the finished word waits in the output register and
// the back end holds at its next report; the queue fills and tready falls.
// Reset clears the queues, the live set and the running process and sets
// quantum_mode to 1 (quantum of 2^level ticks). No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_feedback_scheduler_core #(
    parameter int MAX_PROCS  = 16,
    parameter int NUM_LEVELS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Quantum mode register.
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_wr_data,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [mfq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // proc_id, service_time
    input  wire logic                            s_axis_tuser,  // opcode
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [mfq_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // run_id, run_level
    output logic                                 m_axis_tuser,  // busy_res
    output logic                                 m_axis_tlast   // done_res
);
    import mfq_pkg::*;

    logic        queue_full;
    logic        push_en;
    mfq_cmd_t    push_cmd;
    logic        cmd_valid;
    mfq_cmd_t    cmd;
    logic        cmd_pop;
    mfq_result_t res;

    mfq_front #(
        .MAX_PROCS (MAX_PROCS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push_en       (push_en),
        .push_cmd      (push_cmd)
    );

    mfq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push_en),
        .wr_cmd   (push_cmd),
        .full     (queue_full),
        .rd_valid (cmd_valid),
        .rd_cmd   (cmd),
        .rd_en    (cmd_pop)
    );

    mfq_back #(
        .MAX_PROCS  (MAX_PROCS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    // Pack the report word.
    assign m_axis_tdata = {{(M_TDATA_W-ID_W-RLVL_W){1'b0}}, res.run_level, res.run_id};
    assign m_axis_tuser = res.busy;
    assign m_axis_tlast = res.done;

endmodule

`default_nettype wire

### rtl/core/mfq_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mfq_checker #(
    parameter int MAX_PROCS  = 16,
    parameter int NUM_LEVELS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata,
    input  wire logic       m_axis_tuser,
    input  wire logic       m_axis_tlast
);

    // A stalled report holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled report changed");

    // An idle tick reports nothing but zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 8'd0) && !m_axis_tlast)
        else $error("idle report carries data");

    // Only a process that ran can finish.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("finish without a running process");

    // A running process has a legal ID and level.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            ({28'd0, m_axis_tdata[3:0]} < 32'(MAX_PROCS))
            && ({29'd0, m_axis_tdata[6:4]} < 32'(NUM_LEVELS)))
        else $error("reported ID or level out of range");

endmodule

bind multilevel_feedback_scheduler_core mfq_checker #(
    .MAX_PROCS  (MAX_PROCS),
    .NUM_LEVELS (NUM_LEVELS)
) u_mfq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### dv/mfq_schedule_checker.sv
// Scoreboard that predicts and checks the tick reports of the feedback scheduler.
`timescale 1ns / 1ps

module mfq_schedule_checker #(
    parameter int MAX_PROCS  = 16,
    parameter int NUM_LEVELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [mfq_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // proc_id, service_time
    input  logic                             s_axis_tuser,  // opcode
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [mfq_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // run_id, run_level
    input  logic                             m_axis_tuser,  // busy_res
    input  logic                             m_axis_tlast,  // done_res
    output int                               mismatch_count,
    output int                               reports_due
);

    // Shadow copy of the scheduler state.
    logic [mfq_pkg::ID_W-1:0]  ring_ids [NUM_LEVELS][MAX_PROCS];
    int                        level_rd [NUM_LEVELS];
    int                        level_wr [NUM_LEVELS];
    int                        level_depth [NUM_LEVELS];
    logic [mfq_pkg::SVC_W-1:0] svc_left [MAX_PROCS];
    logic [MAX_PROCS-1:0]      live_ids;
    logic                      quantum_mode;
    logic                      active;
    logic [mfq_pkg::ID_W-1:0]  cur_id;
    int                        cur_lvl;
    int                        slice_left;

    // Reports predicted but not yet seen on the output stream.
    mfq_pkg::mfq_result_t      report_q [$];
    mfq_pkg::mfq_result_t      want;

    // Append an ID at the tail of one level; a full level drops it.
    function automatic void push_level(input int lvl, input logic [mfq_pkg::ID_W-1:0] pid);
        if (level_depth[lvl] < MAX_PROCS)
        begin
            ring_ids[lvl][level_wr[lvl]] = pid;
            level_wr[lvl] = (level_wr[lvl] + 1) % MAX_PROCS;
            level_depth[lvl]++;
        end
    endfunction

    // Apply one accepted input word and queue the report a tick produces.
    task automatic schedule_word(input mfq_pkg::op_kind_t op,
                                 input logic [mfq_pkg::ID_W-1:0] pid,
                                 input logic [mfq_pkg::SVC_W-1:0] svc);
        mfq_pkg::mfq_result_t rep;
        int lvl;
        int waiting;
        rep = '0;
        if (op == mfq_pkg::OP_ARRIVE)
        begin
            // Zero service and already live IDs are dropped.
            if (svc != '0 && !live_ids[pid])
            begin
                svc_left[pid] = svc;
                live_ids[pid] = 1'b1;
                push_level(0, pid);
            end
        end
        else
        begin
            // Dispatch from the most urgent non-empty level when idle.
            for (lvl = 0; lvl < NUM_LEVELS; lvl++)
            begin
                if (!active && level_depth[lvl] != 0)
                begin
                    cur_id = ring_ids[lvl][level_rd[lvl]];
                    level_rd[lvl] = (level_rd[lvl] + 1) % MAX_PROCS;
                    level_depth[lvl]--;
                    cur_lvl = lvl;
                    slice_left = quantum_mode ? (1 << lvl) : 1;
                    active = 1'b1;
                end
            end
            // Run the current process for one tick.
            if (active)
            begin
                svc_left[cur_id] = svc_left[cur_id] - 1'b1;
                slice_left--;
                rep.busy = 1'b1;
                rep.run_id = cur_id;
                rep.run_level = cur_lvl[mfq_pkg::RLVL_W-1:0];
                if (svc_left[cur_id] == '0)
                begin
                    rep.done = 1'b1;
                    live_ids[cur_id] = 1'b0;
                    active = 1'b0;
                end
                else if (slice_left == 0)
                begin
                    // A lone process keeps its level; otherwise it sinks one level.
                    active = 1'b0;
                    waiting = 0;
                    for (lvl = 0; lvl < NUM_LEVELS; lvl++)
                        waiting += level_depth[lvl];
                    if (waiting == 0)
                        push_level(cur_lvl, cur_id);
                    else
                        push_level((cur_lvl + 1 < NUM_LEVELS) ? cur_lvl + 1 : NUM_LEVELS - 1,
                                   cur_id);
                end
            end
            report_q = {report_q, rep};
        end
    endtask

    // Compare one report field and count a mismatch.
    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Watch config, output and input traffic at every edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int lvl = 0; lvl < NUM_LEVELS; lvl++)
            begin
                level_rd[lvl] = 0;
                level_wr[lvl] = 0;
                level_depth[lvl] = 0;
            end
            live_ids = '0;
            quantum_mode = 1'b1;
            active = 1'b0;
            cur_id = '0;
            cur_lvl = 0;
            slice_left = 0;
            report_q.delete();
            mismatch_count = 0;
            reports_due <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                quantum_mode = cfg_wr_data;

            // Check an accepted report against the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report word with no tick pending: busy %0d id %0d level %0d done %0d",
                           m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[6:4], m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("busy_res", want.busy, m_axis_tuser);
                    check_field("run_id", want.run_id, m_axis_tdata[mfq_pkg::ID_W-1:0]);
                    check_field("run_level", want.run_level,
                                m_axis_tdata[mfq_pkg::ID_W +: mfq_pkg::RLVL_W]);
                    check_field("done_res", want.done, m_axis_tlast);
                end
            end

            // Predict from an accepted input word.
            if (s_axis_tvalid && s_axis_tready)
                schedule_word(mfq_pkg::op_kind_t'(s_axis_tuser),
                              s_axis_tdata[mfq_pkg::ID_W-1:0],
                              s_axis_tdata[mfq_pkg::ID_W +: mfq_pkg::SVC_W]);

            reports_due <= report_q.size();
        end
    end

endmodule

### dv/testbench.sv
// Top-level testbench driving the feedback scheduler and giving the verdict.
`timescale 1ns / 1ps

module testbench;

    import mfq_pkg::*;

    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 12;
    localparam int STALL_LIMIT    = 3000;
    localparam int PHASE_WORDS    = 110;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // proc_id, service_time
    logic                 s_axis_tuser;   // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // run_id, run_level
    logic                 m_axis_tuser;   // busy_res
    logic                 m_axis_tlast;   // done_res

    int                   mismatch_count;
    int                   reports_due;
    int                   tx_gap_max;
    int                   rx_gap_max;
    int                   next_gap;
    int                   idle_cycles;
    bit                   rx_hold_req;

    multilevel_feedback_scheduler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    mfq_schedule_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    // Free-running 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input op_kind_t op, input logic [ID_W-1:0] pid,
                             input logic [SVC_W-1:0] svc);
        if (next_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (next_gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W - SVC_W - ID_W){1'b0}}, svc, pid};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        next_gap = $urandom_range(0, tx_gap_max);
    endtask

    // Stop sending, let every predicted report arrive, then let the core settle.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the quantum mode register for one cycle.
    task automatic write_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random stalls per word, plus one long hold on request.
    initial
    begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog on cycles with no word moving on either stream.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("multilevel_feedback_scheduler_core test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: directed cases, then random phases under each quantum mode.
    initial
    begin
        int phase;
        int pick;
        logic [SVC_W-1:0] svc;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ARRIVE;
        tx_gap_max    = 4;
        rx_gap_max    = 4;
        next_gap      = 0;
        rx_hold_req   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset mode: idle tick, ignored arrivals, lone process, demotion.
        send_word(OP_TICK, 4'h0, 10'd0);
        send_word(OP_ARRIVE, 4'h0, 10'd0);
        send_word(OP_ARRIVE, 4'hf, 10'd1023);
        send_word(OP_ARRIVE, 4'hf, 10'd7);
        send_word(OP_TICK, 4'hf, 10'd1023);
        send_word(OP_TICK, 4'h0, 10'd0);
        send_word(OP_ARRIVE, 4'h0, 10'd1);
        send_word(OP_TICK, 4'h0, 10'd0);
        send_word(OP_TICK, 4'h0, 10'd0);
        send_word(OP_TICK, 4'h0, 10'd0);
        send_word(OP_ARRIVE, 4'ha, 10'd2);

        // One-tick quanta push competing processes down the levels.
        wait_quiet();
        write_mode(1'b0);
        send_word(OP_ARRIVE, 4'h5, 10'd3);
        send_word(OP_ARRIVE, 4'h6, 10'd9);
        repeat (8) send_word(OP_TICK, 4'h0, 10'd0);

        for (phase = 0; phase < 4; phase++)
        begin
            wait_quiet();
            write_mode(phase[0] ? 1'b0 : 1'b1);

            if (phase == 1)
            begin
                // Long output hold while ticks keep coming, so the input stalls.
                rx_hold_req = 1'b1;
                tx_gap_max = 0;
                repeat (16) send_word(OP_TICK, 4'h0, 10'd0);
                tx_gap_max = 4;
            end
            else if (phase == 2)
            begin
                // No idle cycles on either side.
                tx_gap_max = 0;
                rx_gap_max = 0;
            end
            else
            begin
                tx_gap_max = 4;
                rx_gap_max = 4;
            end

            repeat (PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 38)
                begin
                    // Mostly short jobs, some long ones, a few with no service.
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                        svc = '0;
                    else if (pick < 12)
                        svc = SVC_W'($urandom_range(17, 1023));
                    else
                        svc = SVC_W'($urandom_range(1, 12));
                    send_word(OP_ARRIVE, ID_W'($urandom_range(0, 15)), svc);
                end
                else
                    send_word(OP_TICK, ID_W'($urandom_range(0, 15)),
                              SVC_W'($urandom_range(0, 1023)));
            end
        end

        wait_quiet();
        if (mismatch_count == 0 && reports_due == 0)
            $display("multilevel_feedback_scheduler_core test passed");
        else
            $display("multilevel_feedback_scheduler_core test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/mfq_pkg.sv
rtl/core/mfq_front.sv
rtl/core/mfq_queue.sv
rtl/core/mfq_back.sv
rtl/core/multilevel_feedback_scheduler_core.sv
rtl/core/mfq_checker.sv
dv/mfq_schedule_checker.sv
dv/testbench.sv
